### hdl/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Field widths, request and status codes, and default sizes shared by the
// interfaces, the engine and its checker.
// ----------------------------------------------------------------------------
package ple_pkg;

   // Fixed widths of the transaction fields.
   localparam int REQ_TYPE_W = 3;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 5;
   localparam int STATUS_W   = 2;
   localparam int LENGTH_W   = 5;

   // Widest entry word supported; values are sign-extended to this first.
   localparam int WORD_MAX_W = 64;

   // Defaults for the top-level parameters.
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef logic [REQ_TYPE_W-1:0] op_type;
   typedef logic [STATUS_W-1:0]   status_type;

   // Request codes.
   localparam op_type OP_INSERT_FRONT = 3'd0;
   localparam op_type OP_INSERT_BACK  = 3'd1;
   localparam op_type OP_INSERT_AT    = 3'd2;
   localparam op_type OP_DELETE_FRONT = 3'd3;
   localparam op_type OP_DELETE_BACK  = 3'd4;
   localparam op_type OP_DELETE_AT    = 3'd5;

   // Status codes.
   localparam status_type STAT_OK      = 2'd0;
   localparam status_type STAT_FULL    = 2'd1;
   localparam status_type STAT_EMPTY   = 2'd2;
   localparam status_type STAT_BAD_POS = 2'd3;

endpackage

### hdl/ple_if.sv
// ----------------------------------------------------------------------------
// Positional list engine channels
// Valid/ready request and response channels with source and sink modports.
// ----------------------------------------------------------------------------
interface ple_req_if;
   logic                                valid;
   logic                                ready;
   logic [ple_pkg::REQ_TYPE_W-1:0]      req_type;
   logic signed [ple_pkg::VALUE_W-1:0]  value;
   logic [ple_pkg::POSITION_W-1:0]      position;

   modport source (output valid, output req_type, output value, output position,
                   input ready);
   modport sink   (input valid, input req_type, input value, input position,
                   output ready);
endinterface

interface ple_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ple_pkg::STATUS_W-1:0]    status;
   logic [ple_pkg::LENGTH_W-1:0]    length;

   modport source (output valid, output status, output length, input ready);
   modport sink   (input valid, input status, input length, output ready);
endinterface

### hdl/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// Positional list engine
// An ordered list of up to DEPTH signed words, held in registers that shift
// in parallel, with insert and delete at the front, the back or a position.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Contents
//   --------  ---------  ------------------------------------------------
//   req_port  in         req_type, value, position
//   rsp_port  out        status, length (one response per request)
//
// Each request is accepted, evaluated against the stored
// count and entries, and its response is loaded into the response register
// at the same clock edge. A new request is taken every cycle as long as the
// response register is empty or is being drained in that cycle.
// Reset is synchronous and active high; it empties the list and the response
// register. Entry contents are not reset, since an entry is only meaningful
// once written. A stalled response holds and blocks new requests.
//
module positional_list_engine_unit #(
   parameter int DEPTH      = ple_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ple_req_if.sink   req_port,
   ple_rsp_if.source rsp_port
);

   // The count must hold DEPTH itself.
   localparam int CNT_W = $clog2(DEPTH + 1);
   // Width used for position arithmetic and for widening the count to the
   // length field.
   localparam int EXT_W = (CNT_W > ple_pkg::POSITION_W) ? CNT_W : ple_pkg::POSITION_W;
   localparam int CMP_W = EXT_W + 1;

   // List storage. Entry 0 is the front of the list.
   logic [DATA_WIDTH-1:0] entries_ff [DEPTH];
   logic [DATA_WIDTH-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      cnt_in;

   // Response register.
   logic                          rsp_valid_ff;
   logic [ple_pkg::STATUS_W-1:0]  status_ff;
   logic [ple_pkg::STATUS_W-1:0]  status_in;
   logic [ple_pkg::LENGTH_W-1:0]  length_ff;
   logic [ple_pkg::LENGTH_W-1:0]  length_in;

   logic                          req_accept;
   logic                          list_full;
   logic                          list_empty;
   logic                          do_ins;
   logic                          do_del;
   logic [CMP_W-1:0]              cnt_ext;
   logic [CMP_W-1:0]              pos_ext;
   logic [CMP_W-1:0]              slot;
   logic                          ins_pos_ok;
   logic                          del_pos_ok;
   logic [ple_pkg::WORD_MAX_W-1:0] value_wide;
   logic [DATA_WIDTH-1:0]         word;
   logic [EXT_W-1:0]              cnt_in_ext;

   // The response register can take a new transaction whenever it is empty
   // or its current transaction leaves in this cycle.
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign req_accept     = req_port.valid && req_port.ready;

   assign rsp_port.valid  = rsp_valid_ff;
   assign rsp_port.status = status_ff;
   assign rsp_port.length = length_ff;

   assign list_full  = (cnt_ff == CNT_W'(DEPTH));
   assign list_empty = (cnt_ff == '0);

   assign cnt_ext = CMP_W'(cnt_ff);
   assign pos_ext = CMP_W'(req_port.position);

   // Insert at accepts positions 1 through count+1; delete at accepts
   // positions 1 through count.
   assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
   assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);

   // The incoming word is sign-extended and then cut to the entry width.
   assign value_wide = {{(ple_pkg::WORD_MAX_W - ple_pkg::VALUE_W){req_port.value[ple_pkg::VALUE_W-1]}},
                        req_port.value};
   assign word       = value_wide[DATA_WIDTH-1:0];

   // Decode the request into an insert or delete at a zero-based slot and a
   // status. Full and empty checks take priority over the position check.
   always_comb begin
      do_ins    = 1'b0;
      do_del    = 1'b0;
      slot      = '0;
      status_in = ple_pkg::STAT_OK;
      case (req_port.req_type)
         ple_pkg::OP_INSERT_FRONT: begin
            if (list_full) begin
               status_in = ple_pkg::STAT_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         ple_pkg::OP_INSERT_BACK: begin
            if (list_full) begin
               status_in = ple_pkg::STAT_FULL;
            end else begin
               do_ins = 1'b1;
               slot   = cnt_ext;
            end
         end
         ple_pkg::OP_INSERT_AT: begin
            if (list_full) begin
               status_in = ple_pkg::STAT_FULL;
            end else if (ins_pos_ok) begin
               do_ins = 1'b1;
               slot   = pos_ext - CMP_W'(1);
            end else begin
               status_in = ple_pkg::STAT_BAD_POS;
            end
         end
         ple_pkg::OP_DELETE_FRONT: begin
            if (list_empty) begin
               status_in = ple_pkg::STAT_EMPTY;
            end else begin
               do_del = 1'b1;
            end
         end
         ple_pkg::OP_DELETE_BACK: begin
            if (list_empty) begin
               status_in = ple_pkg::STAT_EMPTY;
            end else begin
               do_del = 1'b1;
               slot   = cnt_ext - CMP_W'(1);
            end
         end
         ple_pkg::OP_DELETE_AT: begin
            if (list_empty) begin
               status_in = ple_pkg::STAT_EMPTY;
            end else if (del_pos_ok) begin
               do_del = 1'b1;
               slot   = pos_ext - CMP_W'(1);
            end else begin
               status_in = ple_pkg::STAT_BAD_POS;
            end
         end
         default: begin
            // Unused request codes leave the list alone and report success.
            status_in = ple_pkg::STAT_OK;
         end
      endcase
   end

   // New count and the reported length, which is the count cut to the
   // length field.
   always_comb begin
      cnt_in = cnt_ff;
      if (do_ins) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_del) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   assign cnt_in_ext = EXT_W'(cnt_in);
   assign length_in  = cnt_in_ext[ple_pkg::LENGTH_W-1:0];

   // Every entry picks its next value independently: it keeps its word, takes
   // the new word, takes its front neighbor's word on insert (shift toward the
   // back) or its back neighbor's word on delete (shift toward the front).
   // Words moved into slots past the end of the list are never observed.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
      end
      if (do_ins) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (CMP_W'(i) == slot) begin
               entries_in[i] = word;
            end
         end
         for (int i = 1; i < DEPTH; i++) begin
            if (CMP_W'(i) > slot) begin
               entries_in[i] = entries_ff[i-1];
            end
         end
      end else if (do_del) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (CMP_W'(i) >= slot) begin
               entries_in[i] = entries_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         entries_ff <= entries_in;
         status_ff  <= status_in;
         length_ff  <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            cnt_ff <= cnt_in;
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### hdl/ple_checker.sv
// ----------------------------------------------------------------------------
// Positional list engine checker
// Port-level assertions on the engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ple_checker #(
   parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ple_pkg::STATUS_W-1:0] rsp_status,
   input logic [ple_pkg::LENGTH_W-1:0] rsp_length
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_length))
      else $error("response changed while stalled");

   // Every accepted request produces a response in the next cycle.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   // With no response pending the engine must take requests.
   a_ready_when_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty response register");

   // An empty status means the list really is empty; a full status means it
   // is at capacity.
   a_status_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_status != ple_pkg::STAT_EMPTY || rsp_length == '0) &&
         (rsp_status != ple_pkg::STAT_FULL  || rsp_length == ple_pkg::LENGTH_W'(DEPTH)))
      else $error("status disagrees with reported length");

   // The reported length never exceeds the capacity when it fits the field.
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH > 31) || (rsp_length <= ple_pkg::LENGTH_W'(DEPTH)))
      else $error("reported length exceeds capacity");

endmodule

bind positional_list_engine_unit ple_checker #(
   .DEPTH(DEPTH)
) u_ple_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_status (rsp_port.status),
   .rsp_length (rsp_port.length)
);
